// ===== rtl/sine_oscillator_glide_gain_ramp_top_macros.svh =====
// Assertion shorthands for the oscillator block.
// They expect clk and rst_n in the scope where they are used.
`ifndef SINE_OSCILLATOR_GLIDE_GAIN_RAMP_TOP_MACROS_SVH
`define SINE_OSCILLATOR_GLIDE_GAIN_RAMP_TOP_MACROS_SVH

// Consequent checked in the same cycle
`define SOGR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the next cycle
`define SOGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sogr_pkg.sv =====
package sogr_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_BLOCK_DEF       = 4096;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int BLK_LEN_W  = 13;
  localparam logic REG_BLOCK_LENGTH     = 1'b0;
  localparam logic REG_PHASE_STEP_SCALE = 1'b1;
  localparam logic [BLK_LEN_W-1:0]  BLOCK_LENGTH_RESET = 13'd512;
  localparam logic [CFG_DATA_W-1:0] STEP_SCALE_RESET   = 32'd366503876;

  // State memory geometry
  localparam int STATE_W     = 34;
  localparam int STATE_DEPTH = 8;
  localparam logic [STATE_W-1:0] CUR_FREQ_RESET = 34'd8000 << 16;

  // Width of the ramp difference handed to the divider
  localparam int DIV_W = 35;

  // 2*pi in Q30
  localparam longint TWO_PI_Q30 = 64'sd6746518852;

  typedef enum logic [2:0] {
    SA_PHASE,
    SA_CUR_FREQ,
    SA_FREQ_INC,
    SA_CUR_GAIN,
    SA_GAIN_INC,
    SA_BLK_POS,
    SA_LAT_FREQ,
    SA_LAT_LEVEL
  } st_addr_t;

  typedef struct packed {
    logic               we;
    st_addr_t           waddr;
    logic [STATE_W-1:0] wdata;
    st_addr_t           raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_PREP,
    S_DIV_F,
    S_DIV_G,
    S_UPDATE,
    S_STEP,
    S_WB,
    S_OUT
  } fsm_t;

  // Value a state word holds before its first write-back
  function automatic logic [STATE_W-1:0] state_reset_value(input st_addr_t a);
    case (a)
      SA_CUR_FREQ: return CUR_FREQ_RESET;
      default:     return '0;
    endcase
  endfunction

  // Truncating quotient of a non-negative value, restoring shift and subtract
  function automatic longint shift_sub_div(input longint n, input longint d);
    longint q;
    longint rem;
    q = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((n >>> b) & longint'(1));
      if (rem >= d) begin
        rem = rem - d;
        q = q | (longint'(1) <<< b);
      end
    end
    return q;
  endfunction

  // round(sin(a * 2pi / 2^bits) * 2^15) by an 11th-order Taylor series in Q30
  function automatic logic signed [15:0] quarter_sine(input int unsigned a,
                                                      input int unsigned bits);
    longint x;
    longint term;
    longint sum;
    longint v;
    x = (longint'(a) * TWO_PI_Q30) >>> bits;
    term = x;
    sum = x;
    for (int k = 1; k <= 5; k++) begin
      term = (term * x) >>> 30;
      term = (term * x) >>> 30;
      // terms stay non-negative, so the plain magnitude quotient truncates toward zero
      term = shift_sub_div(term, longint'((2 * k) * (2 * k + 1)));
      if ((k & 1) == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    v = (sum + (longint'(1) <<< 14)) >>> 15;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

endpackage

// ===== rtl/sine_oscillator_glide_gain_ramp_top.sv =====
// An input transaction is taken only while the sequencer is idle; the sequencer then
// loads the eight state words from the state memory, runs two divisions for the ramp
// steps on the first sample of a block, computes the sample, writes the words back one
// per cycle and loads the sample into the output register before it takes another item.
// Reset: synchronous, active low; config returns to 512 / 366503876 and the state words
// read as reset values through valid bits until written, so no clearing pass is needed.
`include "sine_oscillator_glide_gain_ramp_top_macros.svh"

module sine_oscillator_glide_gain_ramp_top #(
  parameter int MAX_BLOCK       = sogr_pkg::MAX_BLOCK_DEF,
  parameter int SINE_TABLE_BITS = sogr_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [16:0] target_frequency, [31:17] target_level
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [15:0] sample_value (signed)
  output logic                            out_tlast,  // last_of_block
  // register port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sogr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sogr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sogr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import sogr_pkg::*;

  localparam int LEN_W = $clog2(MAX_BLOCK + 1);
  localparam int POS_W = $clog2(MAX_BLOCK);

  // Configuration registers
  logic [BLK_LEN_W-1:0]  block_length_r;
  logic [CFG_DATA_W-1:0] scale_r;
  logic                  cfg_wr;
  logic [LEN_W-1:0]      len;

  // Sequencer
  fsm_t       state_r;
  fsm_t       state_nxt;
  logic [3:0] cnt_r;
  st_addr_t   ld_addr;
  st_addr_t   seq_addr;

  // Memory, divider, table
  mem_req_t              mem_req;
  logic [STATE_W-1:0]    mem_rdata;
  logic                  div_start;
  logic signed [DIV_W-1:0] div_num;
  logic                  div_busy;
  logic                  div_done;
  logic signed [DIV_W-1:0] div_quo;
  logic signed [15:0]    sine_q;

  // Working copy of the state
  logic [16:0]           in_freq_r;
  logic [14:0]           in_level_r;
  logic [31:0]           phase_r;
  logic [33:0]           cf_r;
  logic signed [33:0]    finc_r;
  logic [31:0]           cg_r;
  logic signed [31:0]    ginc_r;
  logic [POS_W-1:0]      pos_r;
  logic [16:0]           lf_r;
  logic [14:0]           ll_r;
  logic [33:0]           cf_step_r;
  logic [31:0]           cg_step_r;
  logic signed [15:0]    sample_r;
  logic [31:0]           step_r;

  // Output register
  logic                  out_valid_r;
  logic [15:0]           out_data_r;
  logic                  out_last_r;

  // Datapath nets
  logic signed [DIV_W-1:0] fdiff;
  logic signed [DIV_W-1:0] gdiff;
  logic signed [34:0]    f_sum;
  logic signed [34:0]    f_tgt;
  logic signed [34:0]    cf_stepped;
  logic signed [32:0]    g_sum;
  logic signed [32:0]    g_tgt;
  logic signed [32:0]    cg_stepped;
  logic signed [32:0]    sg_prod;
  logic [49:0]           step_prod;
  logic [31:0]           phase_new;
  logic [LEN_W-1:0]      pos_inc;
  logic                  wb_last;
  logic [33:0]           cf_fin;
  logic [31:0]           cg_fin;
  logic [POS_W-1:0]      pos_new;
  logic [STATE_W-1:0]    wb_data;
  logic                  out_load;

  // ---------------- register port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_length_r <= BLOCK_LENGTH_RESET;
      scale_r        <= STEP_SCALE_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_BLOCK_LENGTH:     block_length_r <= cfg_pwdata[BLK_LEN_W-1:0];
        REG_PHASE_STEP_SCALE: scale_r        <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_BLOCK_LENGTH:     cfg_prdata = CFG_DATA_W'(block_length_r);
      REG_PHASE_STEP_SCALE: cfg_prdata = scale_r;
      default:              cfg_prdata = '0;
    endcase
  end

  // Block length clamped to 1..MAX_BLOCK
  always_comb begin
    if (block_length_r == '0) begin
      len = LEN_W'(1);
    end else if (32'(block_length_r) > 32'(MAX_BLOCK)) begin
      len = LEN_W'(MAX_BLOCK);
    end else begin
      len = LEN_W'(block_length_r);
    end
  end

  // ---------------- submodules ----------------
  sogr_state_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  sogr_div #(
    .DW (DIV_W),
    .LW (LEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (len),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  sogr_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (phase_r[31 -: SINE_TABLE_BITS]),
    .data (sine_q)
  );

  // ---------------- arithmetic ----------------
  // Ramp differences toward the new targets
  assign fdiff = $signed({2'b00, in_freq_r, 16'h0000}) - $signed({1'b0, cf_r});
  assign gdiff = $signed({4'b0000, ll_r, 16'h0000}) - $signed({3'b000, cg_r});

  // Frequency step, never past the target
  always_comb begin
    f_sum      = $signed({1'b0, cf_r}) + $signed({finc_r[33], finc_r});
    f_tgt      = $signed({2'b00, lf_r, 16'h0000});
    cf_stepped = f_sum;
    if ((finc_r > 0) && (f_sum > f_tgt)) cf_stepped = f_tgt;
    if ((finc_r < 0) && (f_sum < f_tgt)) cf_stepped = f_tgt;
  end

  // Gain step, never past the target
  always_comb begin
    g_sum      = $signed({1'b0, cg_r}) + $signed({ginc_r[31], ginc_r});
    g_tgt      = $signed({2'b00, ll_r, 16'h0000});
    cg_stepped = g_sum;
    if ((ginc_r > 0) && (g_sum > g_tgt)) cg_stepped = g_tgt;
    if ((ginc_r < 0) && (g_sum < g_tgt)) cg_stepped = g_tgt;
  end

  // Sine times gain; arithmetic shift floors
  assign sg_prod   = sine_q * $signed({1'b0, cg_r[31:16]});
  assign step_prod = cf_step_r[33:16] * scale_r;

  // End-of-sample update
  assign phase_new = phase_r + step_r;
  assign pos_inc   = LEN_W'(pos_r) + LEN_W'(1);
  assign wb_last   = pos_inc >= len;
  assign cf_fin    = wb_last ? {1'b0, lf_r, 16'h0000} : cf_step_r;
  assign cg_fin    = wb_last ? {1'b0, ll_r, 16'h0000} : cg_step_r;
  assign pos_new   = wb_last ? '0 : POS_W'(pos_inc);

  assign seq_addr = st_addr_t'(cnt_r[2:0]);
  assign ld_addr  = st_addr_t'(3'(cnt_r - 4'd1));

  always_comb begin
    case (seq_addr)
      SA_PHASE:     wb_data = STATE_W'(phase_new);
      SA_CUR_FREQ:  wb_data = cf_fin;
      SA_FREQ_INC:  wb_data = finc_r;
      SA_CUR_GAIN:  wb_data = STATE_W'(cg_fin);
      SA_GAIN_INC:  wb_data = {2'b00, ginc_r};
      SA_BLK_POS:   wb_data = STATE_W'(pos_new);
      SA_LAT_FREQ:  wb_data = STATE_W'(lf_r);
      SA_LAT_LEVEL: wb_data = STATE_W'(ll_r);
      default:      wb_data = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= ((state_r == S_LOAD) || (state_r == S_WB)) ? cnt_r + 4'd1 : '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    div_start     = 1'b0;
    div_num       = fdiff;
    out_load      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = seq_addr;
    mem_req.wdata = wb_data;
    mem_req.raddr = seq_addr;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = S_LOAD;
      end
      // read addresses 0..7, capture each in the next cycle
      S_LOAD: begin
        if (cnt_r == 4'd8) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (pos_r == '0) begin
          div_start = 1'b1;
          div_num   = fdiff;
          state_nxt = S_DIV_F;
        end else begin
          state_nxt = S_UPDATE;
        end
      end
      S_DIV_F: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = gdiff;
          state_nxt = S_DIV_G;
        end
      end
      S_DIV_G: begin
        if (div_done) state_nxt = S_UPDATE;
      end
      S_UPDATE: state_nxt = S_STEP;
      S_STEP:   state_nxt = S_WB;
      S_WB: begin
        mem_req.we = 1'b1;
        if (cnt_r == 4'd7) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          in_freq_r  <= in_tdata[16:0];
          in_level_r <= in_tdata[31:17];
        end
      end
      S_LOAD: begin
        if (cnt_r != '0) begin
          case (ld_addr)
            SA_PHASE:     phase_r <= mem_rdata[31:0];
            SA_CUR_FREQ:  cf_r    <= mem_rdata;
            SA_FREQ_INC:  finc_r  <= mem_rdata;
            SA_CUR_GAIN:  cg_r    <= mem_rdata[31:0];
            SA_GAIN_INC:  ginc_r  <= mem_rdata[31:0];
            SA_BLK_POS:   pos_r   <= mem_rdata[POS_W-1:0];
            SA_LAT_FREQ:  lf_r    <= mem_rdata[16:0];
            SA_LAT_LEVEL: ll_r    <= mem_rdata[14:0];
            default: ;
          endcase
        end
      end
      // block start: latch targets
      S_PREP: begin
        if (pos_r == '0) begin
          lf_r <= in_freq_r;
          ll_r <= in_level_r;
        end
      end
      S_DIV_F: begin
        if (div_done) finc_r <= div_quo[33:0];
      end
      S_DIV_G: begin
        if (div_done) ginc_r <= div_quo[31:0];
      end
      S_UPDATE: begin
        sample_r  <= sg_prod[31:16];
        cf_step_r <= cf_stepped[33:0];
        cg_step_r <= cg_stepped[31:0];
      end
      S_STEP: begin
        step_r <= step_prod[47:16];
      end
      S_OUT: begin
        if (out_load) begin
          out_data_r <= sample_r;
          out_last_r <= wb_last;
        end
      end
      default: ;
    endcase
  end

  // Output register, free again once the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ---------------- checks ----------------
  `SOGR_ASSERT_SAME(a_div_start_idle, div_start, !div_busy, "divider started while busy")
  `SOGR_ASSERT_NEXT(a_out_loaded, (state_r == S_OUT) && (state_nxt == S_IDLE), out_tvalid, "result not presented after write-back")
  `SOGR_ASSERT_NEXT(a_accept_loads, in_tvalid && in_tready, (state_r == S_LOAD) && (cnt_r == 4'd0), "accepted item did not start a state load")
  `SOGR_ASSERT_NEXT(a_freq_no_overshoot, (state_r == S_UPDATE) && (finc_r > 0), {1'b0, cf_step_r} <= {2'b00, lf_r, 16'h0000}, "rising frequency passed its target")

endmodule

// ===== rtl/sogr_state_mem.sv =====
// Oscillator state words, one synchronous port pair, registered read.
// Valid bits make unwritten words read as their reset values.
module sogr_state_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sogr_pkg::mem_req_t            req,
  output logic [sogr_pkg::STATE_W-1:0]  rdata
);
  import sogr_pkg::*;

  logic [STATE_W-1:0]     ram_r [STATE_DEPTH];
  logic [STATE_DEPTH-1:0] valid_r;
  logic [STATE_W-1:0]     rd_data_r;
  logic [STATE_W-1:0]     rd_rst_r;
  logic                   rd_valid_r;

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      ram_r[req.waddr] <= req.wdata;
    end
    rd_data_r <= ram_r[req.raddr];
    rd_rst_r  <= state_reset_value(req.raddr);
  end

  // Written flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.we) begin
        valid_r[req.waddr] <= 1'b1;
      end
      rd_valid_r <= valid_r[req.raddr];
    end
  end

  assign rdata = rd_valid_r ? rd_data_r : rd_rst_r;

endmodule

// ===== rtl/sogr_div.sv =====
// Signed by unsigned divide, truncating toward zero, one quotient bit per cycle.
module sogr_div #(
  parameter int DW = sogr_pkg::DIV_W,
  parameter int LW = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] num,
  input  logic [LW-1:0]        den,
  output logic                 busy,
  output logic                 done,
  output logic signed [DW-1:0] quo
);
  import sogr_pkg::*;

  localparam int CW = $clog2(DW);

  logic          busy_r;
  logic          done_r;
  logic          neg_r;
  logic [DW-1:0] q_r;
  logic [LW-1:0] rem_r;
  logic [LW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic [LW:0]   trial;
  logic          fits;

  assign trial = {rem_r, q_r[DW-1]};
  assign fits  = trial >= {1'b0, den_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Magnitude shift-subtract
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[DW-1];
      q_r   <= num[DW-1] ? DW'(-num) : DW'(num);
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? LW'(trial - {1'b0, den_r}) : trial[LW-1:0];
      q_r   <= {q_r[DW-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = neg_r ? $signed(-q_r) : $signed(q_r);

endmodule

// ===== rtl/sogr_sine_rom.sv =====
// Full-wave sine table, Q15, registered read.
module sogr_sine_rom #(
  parameter int TABLE_BITS = sogr_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic [TABLE_BITS-1:0]   addr,
  output logic signed [15:0]      data
);
  import sogr_pkg::*;

  localparam int SIZE    = 1 << TABLE_BITS;
  localparam int QUARTER = SIZE / 4;

  typedef logic signed [15:0] rom_t [SIZE];

  // Quarter wave mirrored into the other three quadrants
  function automatic rom_t build_rom();
    rom_t               t;
    int unsigned        q;
    int unsigned        r;
    int unsigned        a;
    logic signed [15:0] v;
    for (int unsigned i = 0; i < SIZE; i++) begin
      q = (i >> (TABLE_BITS - 2)) & 3;
      r = i & (QUARTER - 1);
      a = q[0] ? (QUARTER - r) : r;
      v = quarter_sine(a, TABLE_BITS);
      t[i] = q[1] ? -v : v;
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic signed [15:0] data_r;

  always_ff @(posedge clk) begin
    data_r <= SINE_ROM[addr];
  end

  assign data = data_r;

endmodule

// ===== bench/sine_oscillator_glide_gain_ramp_top_tb.sv =====
module sine_oscillator_glide_gain_ramp_top_tb;

  localparam int TBL_BITS       = sogr_pkg::SINE_TABLE_BITS_DEF;
  localparam int TBL_SIZE       = 1 << TBL_BITS;
  localparam int LONGEST_BLOCK  = sogr_pkg::MAX_BLOCK_DEF;
  localparam int QUIET_LIMIT    = 4000;
  localparam int HOLD_CYCLES    = 500;
  localparam int DRAIN_CYCLES   = 120;
  localparam int DIR_ROWS       = 27;
  localparam int N_PHASES       = 9;
  localparam int PRESSURE_PHASE = 2;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_SET_LENGTH, ROW_SET_SCALE} row_kind_t;
  typedef enum logic [1:0] {PACE_FULL, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } osc_out_t;

  // arg_a/arg_b: frequency/level for a sample row, arg_a is the value for a register row
  typedef struct packed {
    row_kind_t          kind;
    logic [31:0]        arg_a;
    logic [31:0]        arg_b;
    logic               typed;
    logic signed [15:0] sample;
    logic               last;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] length;
    logic [31:0] scale;
    pace_t       pace;
    logic [15:0] count;
  } phase_plan_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;     // [16:0] target_frequency, [31:17] target_level
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;    // [15:0] sample_value (signed)
  logic        out_tlast;    // last_of_block
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [sogr_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [sogr_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [sogr_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic        cfg_pready;

  sine_oscillator_glide_gain_ramp_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Oscillator state as the predictor sees it
  logic signed [15:0] sine_lut [TBL_SIZE];
  logic [31:0]        osc_phase;
  longint             osc_freq;
  longint             osc_freq_step;
  longint             osc_gain;
  longint             osc_gain_step;
  longint             osc_pos;
  logic [16:0]        osc_lat_freq;
  logic [14:0]        osc_lat_level;
  logic [sogr_pkg::BLK_LEN_W-1:0] osc_len_reg;
  logic [31:0]        osc_scale;

  osc_out_t expected_samples [$];
  osc_out_t due_sample;
  int       mismatches;
  int       quiet_cycles;
  int       gap_pct;
  int       stall_pct;
  bit       hold_request;
  int       hold_left;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // gain is zero right after reset
    '{ROW_SAMPLE, 32'd80000, 32'd16384, 1'b1, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'h1FFFF, 32'h7FFF, 1'b0, 16'sd0, 1'b0},
    // shorten the block while it is running
    '{ROW_SET_LENGTH, 32'd1, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'd0, 32'd0, 1'b1, 16'sd0, 1'b1},
    // frozen phase
    '{ROW_SET_SCALE, 32'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'd80000, 32'd16384, 1'b1, 16'sd0, 1'b1},
    '{ROW_SAMPLE, 32'h1FFFF, 32'h7FFF, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    // largest step scale
    '{ROW_SET_SCALE, 32'hFFFFFFFF, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'h1FFFF, 32'h7FFF, 1'b1, 16'sd0, 1'b1},
    '{ROW_SAMPLE, 32'h1FFFF, 32'h7FFF, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'd1, 32'd1, 1'b0, 16'sd0, 1'b0},
    // zero length clamps to one
    '{ROW_SET_LENGTH, 32'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'h15555, 32'h2AAA, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'h0AAAA, 32'h5555, 1'b0, 16'sd0, 1'b0},
    // oversized length clamps to the maximum block
    '{ROW_SET_LENGTH, 32'h1FFF, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'd80000, 32'd16384, 1'b0, 16'sd0, 1'b0},
    // cut the long block short, then short ramps
    '{ROW_SET_LENGTH, 32'd3, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'd40000, 32'd8192, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'd12345, 32'd100, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'd80000, 32'd16384, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 32'd0, 32'd16384, 1'b0, 16'sd0, 1'b0},
    '{ROW_SET_SCALE, sogr_pkg::STEP_SCALE_RESET, 32'd0, 1'b0, 16'sd0, 1'b0}
  };

  localparam phase_plan_t PLANS [N_PHASES] = '{
    '{32'd4,    sogr_pkg::STEP_SCALE_RESET, PACE_FULL,     16'd200},
    '{32'd16,   32'd91625969,               PACE_SENDER,   16'd250},
    '{32'd1,    32'd1466015504,             PACE_RECEIVER, 16'd250},
    '{32'd7,    sogr_pkg::STEP_SCALE_RESET, PACE_BOTH,     16'd250},
    '{32'd64,   32'hFFFFFFFF,               PACE_FULL,     16'd250},
    '{32'd2,    32'd0,                      PACE_RECEIVER, 16'd200},
    '{32'd4096, sogr_pkg::STEP_SCALE_RESET, PACE_SENDER,   16'd200},
    '{32'd5,    32'd2000000000,             PACE_BOTH,     16'd150},
    '{32'd512,  sogr_pkg::STEP_SCALE_RESET, PACE_FULL,     16'd100}
  };

  // Quarter-wave sine in Q15: Taylor series to x^11 in Q30, products truncated
  function automatic logic signed [15:0] sine_q15_quarter(input int unsigned a);
    longint ang;
    longint pw;
    longint acc;
    longint rounded;
    ang = (longint'(a) * sogr_pkg::TWO_PI_Q30) >>> TBL_BITS;
    pw = ang;
    acc = ang;
    for (int n = 1; n <= 5; n++) begin
      pw = (pw * ang) >>> 30;
      pw = (pw * ang) >>> 30;
      pw = pw / longint'((2 * n) * (2 * n + 1));
      acc = (n % 2 == 1) ? acc - pw : acc + pw;
    end
    if (acc < 0) acc = 0;
    rounded = (acc + 64'sd16384) >>> 15;
    if (rounded > 32767) rounded = 32767;
    return 16'(rounded);
  endfunction

  // Ramp one step, never past the goal
  function automatic longint glide(input longint cur, input longint inc, input longint goal);
    longint n;
    n = cur + inc;
    if (inc > 0 && n > goal) n = goal;
    if (inc < 0 && n < goal) n = goal;
    return n;
  endfunction

  // Advance the oscillator by one sample and return what it puts out
  function automatic osc_out_t next_sample(input logic [16:0] freq, input logic [14:0] level);
    longint   span;
    longint   f_goal;
    longint   g_goal;
    longint   prod;
    longint   step;
    osc_out_t r;
    if (osc_len_reg < 1) span = 1;
    else if (osc_len_reg > LONGEST_BLOCK) span = LONGEST_BLOCK;
    else span = longint'(osc_len_reg);
    if (osc_pos == 0) begin
      osc_lat_freq = freq;
      osc_lat_level = level;
      osc_freq_step = ((longint'(freq) <<< 16) - osc_freq) / span;
      osc_gain_step = ((longint'(level) <<< 16) - osc_gain) / span;
    end
    f_goal = longint'(osc_lat_freq) <<< 16;
    g_goal = longint'(osc_lat_level) <<< 16;
    prod = longint'(sine_lut[osc_phase[31 -: TBL_BITS]]) * (osc_gain >>> 16);
    r.sample = 16'(prod >>> 16);
    osc_freq = glide(osc_freq, osc_freq_step, f_goal);
    osc_gain = glide(osc_gain, osc_gain_step, g_goal);
    step = ((osc_freq >>> 16) * longint'(osc_scale)) >>> 16;
    osc_phase = osc_phase + 32'(step);
    r.last = (osc_pos + 1 >= span);
    if (r.last) begin
      osc_freq = f_goal;
      osc_gain = g_goal;
      osc_pos = 0;
    end else begin
      osc_pos = osc_pos + 1;
    end
    return r;
  endfunction

  // Random targets: mostly in range, some extremes, some full-width
  function automatic logic [31:0] pick_targets();
    logic [16:0] f;
    logic [14:0] l;
    case ($urandom_range(9))
      0: begin
        f = ($urandom_range(2) == 0) ? 17'd0 : ($urandom_range(1) ? 17'd80000 : '1);
        l = ($urandom_range(2) == 0) ? 15'd0 : ($urandom_range(1) ? 15'd16384 : '1);
      end
      1: begin
        f = 17'($urandom);
        l = 15'($urandom);
      end
      default: begin
        f = 17'($urandom_range(80000));
        l = 15'($urandom_range(16384));
      end
    endcase
    return {l, f};
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // One input transaction; the expected sample is queued at acceptance
  task automatic offer_targets(input logic [31:0] word, input logic typed, input osc_out_t given);
    osc_out_t p;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
    p = next_sample(word[16:0], word[31:17]);
    expected_samples.push_back(typed ? given : p);
  endtask

  // Register write and readback, only once the oscillator has drained
  task automatic program_register(input logic reg_sel, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] held;
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_sel, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_sel == sogr_pkg::REG_BLOCK_LENGTH) begin
      osc_len_reg = value[sogr_pkg::BLK_LEN_W-1:0];
      held = 32'(value[sogr_pkg::BLK_LEN_W-1:0]);
    end else begin
      osc_scale = value;
      held = value;
    end
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== held) report_mismatch("register readback", readback, held);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each output transaction with the oldest expected sample
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("sample with nothing expected", $signed(out_tdata), 0);
      end else begin
        due_sample = expected_samples.pop_front();
        if (out_tdata !== due_sample.sample)
          report_mismatch("sample_value", $signed(out_tdata), due_sample.sample);
        if (out_tlast !== due_sample.last)
          report_mismatch("last_of_block", out_tlast, due_sample.last);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned quad;
    int unsigned ofs;
    logic signed [15:0] v;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    mismatches = 0;
    quiet_cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    hold_request = 1'b0;

    // sine table, built by quadrant symmetry
    for (int i = 0; i < TBL_SIZE; i++) begin
      quad = (i >> (TBL_BITS - 2)) & 3;
      ofs = i & (TBL_SIZE / 4 - 1);
      v = sine_q15_quarter((quad & 1) ? (TBL_SIZE / 4 - ofs) : ofs);
      sine_lut[i] = (quad & 2) ? -v : v;
    end

    // predictor state after reset
    osc_len_reg = sogr_pkg::BLOCK_LENGTH_RESET;
    osc_scale = sogr_pkg::STEP_SCALE_RESET;
    osc_phase = '0;
    osc_freq = longint'(8000) <<< 16;
    osc_freq_step = 0;
    osc_gain = 0;
    osc_gain_step = 0;
    osc_pos = 0;
    osc_lat_freq = '0;
    osc_lat_level = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, no idling
    for (int r = 0; r < DIR_ROWS; r++) begin
      case (DIRECTED[r].kind)
        ROW_SET_LENGTH: program_register(sogr_pkg::REG_BLOCK_LENGTH, DIRECTED[r].arg_a);
        ROW_SET_SCALE:  program_register(sogr_pkg::REG_PHASE_STEP_SCALE, DIRECTED[r].arg_a);
        default: offer_targets({DIRECTED[r].arg_b[14:0], DIRECTED[r].arg_a[16:0]},
                               DIRECTED[r].typed, {DIRECTED[r].sample, DIRECTED[r].last});
      endcase
    end

    // random phases, each with its own settings and pacing
    for (int p = 0; p < N_PHASES; p++) begin
      program_register(sogr_pkg::REG_BLOCK_LENGTH, PLANS[p].length);
      program_register(sogr_pkg::REG_PHASE_STEP_SCALE, PLANS[p].scale);
      case (PLANS[p].pace)
        PACE_SENDER: begin
          gap_pct = 52;
          stall_pct = 0;
        end
        PACE_RECEIVER: begin
          gap_pct = 0;
          stall_pct = 52;
        end
        PACE_BOTH: begin
          gap_pct = 9;
          stall_pct = 9;
        end
        default: begin
          gap_pct = 0;
          stall_pct = 0;
        end
      endcase
      for (int i = 0; i < PLANS[p].count; i++) begin
        if (p == PRESSURE_PHASE && i == 20) hold_request = 1'b1;
        offer_targets(pick_targets(), 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sogr_pkg.sv
rtl/sogr_state_mem.sv
rtl/sogr_div.sv
rtl/sogr_sine_rom.sv
rtl/sine_oscillator_glide_gain_ramp_top.sv
bench/sine_oscillator_glide_gain_ramp_top_tb.sv
